### src/dtoi_pkg.sv
// Shared types and constants for the decimal text to int32 converter.
`timescale 1ns / 1ps

package dtoi_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic signed [31:0] INT32_MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN_C = 32'sh8000_0000;
    localparam logic signed [35:0] SUM_MAX     = 36'sd2147483647;
    localparam logic signed [35:0] SUM_MIN     = -36'sd2147483648;

    typedef enum logic [2:0] {
        KIND_SPACE,
        KIND_PLUS,
        KIND_MINUS,
        KIND_DIGIT,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

endpackage

### src/dtoi_front.sv
// Front end: classifies each incoming character beat for the parser.
`timescale 1ns / 1ps

module dtoi_front (
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,   // end_of_text
    output logic                   item_valid,
    input  logic                   item_ready,
    output dtoi_pkg::char_item_t   item
);
    import dtoi_pkg::*;

    logic [3:0] offset;

    assign offset        = 4'(s_axis_tdata - CHAR_ZERO);
    assign item_valid    = s_axis_tvalid;
    assign s_axis_tready = item_ready;

    always_comb
    begin
        item.digit = offset;
        item.last  = s_axis_tlast;
        if (s_axis_tdata == CHAR_SPACE)
        begin
            item.kind = KIND_SPACE;
        end
        else if (s_axis_tdata == CHAR_PLUS)
        begin
            item.kind = KIND_PLUS;
        end
        else if (s_axis_tdata == CHAR_MINUS)
        begin
            item.kind = KIND_MINUS;
        end
        else if (s_axis_tdata >= CHAR_ZERO && s_axis_tdata <= CHAR_NINE)
        begin
            item.kind = KIND_DIGIT;
        end
        else
        begin
            item.kind = KIND_OTHER;
        end
    end

endmodule

### src/dtoi_queue.sv
// Short queue of classified characters between front end and parser.
`timescale 1ns / 1ps

module dtoi_queue #(
    parameter int unsigned DEPTH = dtoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  dtoi_pkg::char_item_t   push_item,
    output logic                   pop_valid,
    input  logic                   pop,
    output dtoi_pkg::char_item_t   pop_item
);
    import dtoi_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    char_item_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/dtoi_back.sv
// Back end: sign and digit accumulation with saturation, result register.
`timescale 1ns / 1ps

module dtoi_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  dtoi_pkg::char_item_t   item,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic signed [31:0]     m_axis_tdata    // [31:0] parsed_value
);
    import dtoi_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] acc_step;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_data_reg, out_data_next;
    logic signed [35:0] acc_wide;
    logic signed [35:0] prod;
    logic signed [35:0] sum;
    logic               digits_go;

    assign item_pop = item_valid && (!item.last || !out_valid_reg || m_axis_tready);

    assign acc_wide = 36'(acc_reg);
    assign prod     = (acc_wide <<< 3) + (acc_wide <<< 1);
    assign sum      = neg_reg ? prod - 36'(item.digit) : prod + 36'(item.digit);

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_step       = acc_reg;
        digits_go      = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (item_pop)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    case (item.kind)
                        KIND_SPACE:
                        begin
                        end
                        KIND_MINUS:
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        KIND_PLUS:
                        begin
                            phase_next = PH_DIGITS;
                        end
                        default:
                        begin
                            phase_next = PH_DIGITS;
                            digits_go  = 1'b1;
                        end
                    endcase
                end
                PH_DIGITS:
                begin
                    digits_go = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (digits_go)
            begin
                if (item.kind != KIND_DIGIT)
                begin
                    phase_next = PH_STOP;
                end
                else if (sum > SUM_MAX)
                begin
                    acc_step   = INT32_MAX_C;
                    phase_next = PH_STOP;
                end
                else if (sum < SUM_MIN)
                begin
                    acc_step   = INT32_MIN_C;
                    phase_next = PH_STOP;
                end
                else
                begin
                    acc_step = sum[31:0];
                end
            end
        end
        acc_next = acc_step;
        if (item_pop && item.last)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc_step;
            phase_next     = PH_SKIP;
            neg_next       = 1'b0;
            acc_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop && item.last |=> phase_reg == PH_SKIP && acc_reg == '0 && !neg_reg)
        else $error("state not returned to reset after final character");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> acc_reg == '0 && !neg_reg)
        else $error("accumulator or sign set while skipping spaces");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !neg_reg |-> !acc_reg[31])
        else $error("negative accumulator without minus sign");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        neg_reg |-> acc_reg[31] || acc_reg == '0)
        else $error("positive accumulator with minus sign");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_pop && item.last && out_valid_reg && !m_axis_tready))
        else $error("result overwritten while stalled");

endmodule

### src/decimal_text_to_int32_saturating.sv
// Top level of the streaming decimal text to saturating int32 converter.
`timescale 1ns / 1ps

// Takes one ASCII character per beat on the slave side, tlast marking the final character
// of a string, and returns the parsed signed 32-bit value as one beat on the master side
// per string. Leading spaces are skipped, one optional sign is taken, digits accumulate and
// saturate at the int32 limits; parsing stops at the first non-digit. Sustained rate is one
// character per clock cycle unless a final character waits on an untaken result; the
// multiply-by-ten and add in the parser are combinational. The final character goes into
// the character queue when accepted; the result register loads when the parser pops it
// from the queue head, once no earlier result is left untaken. The queue's QUEUE_DEPTH
// entries (at least two for full rate) let input keep flowing while a result waits to be
// taken, until a second final character reaches the head of the queue and the queue fills.
module decimal_text_to_int32_saturating #(
    parameter int unsigned QUEUE_DEPTH = dtoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,   // end_of_text
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic signed [31:0] m_axis_tdata    // [31:0] parsed_value
);
    import dtoi_pkg::*;

    char_item_t front_item;
    char_item_t queue_item;
    logic       front_valid;
    logic       front_ready;
    logic       queue_valid;
    logic       queue_pop;

    dtoi_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    dtoi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_item   (queue_item)
    );

    dtoi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (queue_valid),
        .item_pop      (queue_pop),
        .item          (queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### tb/decimal_text_to_int32_saturating_tb.sv
// Self-checking testbench for the streaming decimal text to saturating int32 converter.
`timescale 1ns / 1ps

module decimal_text_to_int32_saturating_tb;

    import dtoi_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_FIRST_AT   = 400;
    localparam int HOLD_GAP        = 1000;
    localparam int PAUSE_FIRST_AT  = 900;
    localparam int PAUSE_GAP       = 700;
    localparam int MODE_ONE_AT     = 630;
    localparam int MODE_TWO_AT     = 1260;
    localparam int TOTAL_CHARS     = 1900;

    typedef enum logic [1:0] {
        SCAN_SKIP,
        SCAN_DIGITS,
        SCAN_STOP
    } scan_phase_t;

    typedef struct {
        logic [7:0] code;
        logic       closing;
        logic       pause_before;
    } text_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic signed [31:0] m_axis_tdata;

    text_beat_t         text_beats[$];
    text_beat_t         next_beat;
    logic signed [31:0] awaited_values[$];
    logic signed [31:0] awaited;
    int                 chars_queued = 0;
    int                 chars_sent = 0;
    int                 closings_sent = 0;
    int                 results_seen = 0;
    int                 mismatch_count = 0;
    int                 hold_count = 0;
    int                 next_hold_at = HOLD_FIRST_AT;
    int                 next_pause_at = PAUSE_FIRST_AT;
    int                 quiet_cycles = 0;
    int                 expected_total = 0;
    logic               pause_next = 1'b0;

    scan_phase_t        scan_phase = SCAN_SKIP;
    logic               scan_negative = 1'b0;
    logic signed [31:0] scan_value = '0;

    decimal_text_to_int32_saturating dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit roll_idle(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int send_idle_pct();
        if (chars_sent < MODE_ONE_AT)
        begin
            return 13;
        end
        else if (chars_sent < MODE_TWO_AT)
        begin
            return 49;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (chars_sent < MODE_ONE_AT)
        begin
            return 49;
        end
        else if (chars_sent < MODE_TWO_AT)
        begin
            return 13;
        end
        return 0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void absorb_char(input logic [7:0] code, input logic closing);
        logic signed [35:0] next_val;
        logic signed [35:0] digit_val;
        logic               as_digit;
        as_digit = 1'b0;
        if (scan_phase == SCAN_SKIP)
        begin
            if (code == CHAR_MINUS)
            begin
                scan_negative = 1'b1;
                scan_phase    = SCAN_DIGITS;
            end
            else if (code == CHAR_PLUS)
            begin
                scan_phase = SCAN_DIGITS;
            end
            else if (code != CHAR_SPACE)
            begin
                scan_phase = SCAN_DIGITS;
                as_digit   = 1'b1;
            end
        end
        else if (scan_phase == SCAN_DIGITS)
        begin
            as_digit = 1'b1;
        end
        if (as_digit)
        begin
            if (code < CHAR_ZERO || code > CHAR_NINE)
            begin
                scan_phase = SCAN_STOP;
            end
            else
            begin
                digit_val = 36'(code - CHAR_ZERO);
                next_val  = 36'(scan_value) * 36'sd10;
                next_val  = scan_negative ? next_val - digit_val : next_val + digit_val;
                if (next_val > 36'sd2147483647)
                begin
                    scan_value = 32'sh7FFF_FFFF;
                    scan_phase = SCAN_STOP;
                end
                else if (next_val < -36'sd2147483648)
                begin
                    scan_value = 32'sh8000_0000;
                    scan_phase = SCAN_STOP;
                end
                else
                begin
                    scan_value = next_val[31:0];
                end
            end
        end
        if (closing)
        begin
            awaited_values.push_back(scan_value);
            scan_phase    = SCAN_SKIP;
            scan_negative = 1'b0;
            scan_value    = '0;
        end
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic closing);
        text_beat_t beat;
        beat.code         = code;
        beat.closing      = closing;
        beat.pause_before = pause_next;
        pause_next        = 1'b0;
        text_beats.push_back(beat);
        chars_queued++;
        absorb_char(code, closing);
    endfunction

    function automatic void add_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            push_char(text[i], (i == text.len() - 1));
        end
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(4))
            0:
            begin
                return CHAR_SPACE;
            end
            1:
            begin
                return CHAR_MINUS;
            end
            2:
            begin
                return CHAR_PLUS;
            end
            3:
            begin
                return 8'(CHAR_ZERO + $urandom_range(9));
            end
            default:
            begin
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    function automatic void add_random_text();
        logic [7:0] chars[$];
        int         n;
        int         style;
        style = int'($urandom_range(9));
        if (style == 0)
        begin
            n = int'($urandom_range(6, 1));
            repeat (n) chars.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n = int'($urandom_range(3));
            repeat (n) chars.push_back(CHAR_SPACE);
            case ($urandom_range(3))
                0:
                begin
                    chars.push_back(CHAR_MINUS);
                end
                1:
                begin
                    chars.push_back(CHAR_PLUS);
                end
                default:
                begin
                end
            endcase
            n = (style < 3) ? int'($urandom_range(13, 9)) : int'($urandom_range(6));
            repeat (n) chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            if ($urandom_range(2) == 0)
            begin
                n = int'($urandom_range(3, 1));
                repeat (n) chars.push_back(pick_char());
            end
        end
        if (chars.size() == 0)
        begin
            chars.push_back(CHAR_SPACE);
        end
        foreach (chars[i])
        begin
            push_char(chars[i], (i == chars.size() - 1));
        end
    endfunction

    // driver: advance to the next queued beat once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                chars_sent++;
                if (s_axis_tlast)
                begin
                    closings_sent++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (text_beats.size() != 0
                    && !(text_beats[0].pause_before && results_seen != closings_sent)
                    && !roll_idle(send_idle_pct()))
                begin
                    next_beat = text_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.code;
                    s_axis_tlast  <= next_beat.closing;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: hold off for long stretches at set points, otherwise idle at random before the last mode
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count--;
            m_axis_tready <= 1'b0;
        end
        else if (chars_sent >= next_hold_at)
        begin
            next_hold_at += HOLD_GAP;
            hold_count = HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !roll_idle(recv_idle_pct());
        end
    end

    // monitor: compare each result beat in order
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_values.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d", m_axis_tdata));
            end
            else
            begin
                awaited = awaited_values.pop_front();
                if (m_axis_tdata !== awaited)
                begin
                    report_mismatch($sformatf("result %0d, expected %0d",
                                              m_axis_tdata, awaited));
                end
            end
            results_seen++;
        end
    end

    // watchdog: drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                report_mismatch("no beat accepted within watchdog limit");
                $display("decimal_text_to_int32_saturating_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        add_text("0");
        add_text("7");
        add_text("-0");
        add_text("+0");
        add_text("2147483647");
        add_text("2147483648");
        add_text("2147483646");
        add_text("214748364");
        add_text("214748365");
        add_text("-214748364");
        add_text("-2147483647");
        add_text("-2147483648");
        add_text("-2147483649");
        add_text("99999999999");
        add_text("-99999999999");
        add_text("0000002147483647");
        add_text("   42");
        add_text("  -17abc");
        add_text("+-5");
        add_text("-+5");
        add_text(" 12 3");
        add_text("12\t3");
        add_text("abc");
        add_text("+");
        add_text("-");
        add_text("   ");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(8'h80, 1'b0);
        push_char(CHAR_ZERO, 1'b1);
        push_char(CHAR_NINE, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(CHAR_NINE, 1'b1);
        while (chars_queued < TOTAL_CHARS)
        begin
            if (chars_queued >= next_pause_at)
            begin
                pause_next    = 1'b1;
                next_pause_at += PAUSE_GAP;
            end
            add_random_text();
        end
        expected_total = awaited_values.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < expected_total)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (results_seen != expected_total || awaited_values.size() != 0)
        begin
            report_mismatch($sformatf("%0d results seen, %0d expected",
                                      results_seen, expected_total));
        end
        if (mismatch_count == 0)
        begin
            $display("decimal_text_to_int32_saturating_tb OK");
        end
        else
        begin
            $display("decimal_text_to_int32_saturating_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
src/dtoi_pkg.sv
src/dtoi_front.sv
src/dtoi_queue.sv
src/dtoi_back.sv
src/decimal_text_to_int32_saturating.sv
tb/decimal_text_to_int32_saturating_tb.sv
